FILE: rtl/core/rsf_pkg.sv
// Shared types and constants for the rotor speed filter and thrust model.
package rsf_pkg;

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;

	// Digit-serial multiplier geometry
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 24;
	localparam int DIG_W     = 4;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_STEPS = MUL_B_W / DIG_W;
	localparam int MUL_CNT_W = 3;

	// Register reset values
	localparam logic [15:0] RST_STEP_LIMIT = 16'hFFFF;
	localparam logic [15:0] RST_MAX_SPEED  = 16'd13408;

	typedef enum logic [2:0] {
		REG_ALPHA_UP     = 3'd0,
		REG_ALPHA_DOWN   = 3'd1,
		REG_STEP_UP      = 3'd2,
		REG_STEP_DOWN    = 3'd3,
		REG_MAX_SPEED    = 3'd4,
		REG_THRUST_COEFF = 3'd5,
		REG_MOMENT_COEFF = 3'd6,
		REG_SPIN_CCW     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        alpha_up;
		logic [15:0]        alpha_down;
		logic [15:0]        step_up_limit;
		logic [15:0]        step_down_limit;
		logic signed [15:0] max_speed;
		logic [23:0]        thrust_coeff;
		logic [15:0]        moment_coeff;
		logic               spin_ccw;
	} cfg_t;

endpackage

FILE: rtl/core/rsf_if.sv
// Valid/ready channel interfaces for speed commands and model results.
interface rsf_cmd_if;
	logic               valid;
	logic               ready;
	logic               cmd_valid;
	logic signed [15:0] cmd_speed;

	modport source (output valid, cmd_valid, cmd_speed, input ready);
	modport sink   (input valid, cmd_valid, cmd_speed, output ready);
endinterface

interface rsf_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] speed_now;
	logic [31:0]        thrust_out;
	logic signed [31:0] yaw_torque;
	logic signed [15:0] speed_next;

	modport source (output valid, speed_now, thrust_out, yaw_torque, speed_next, input ready);
	modport sink   (input valid, speed_now, thrust_out, yaw_torque, speed_next, output ready);
endinterface

FILE: rtl/core/rsf_digit_mul.sv
// Unsigned shift-add multiplier retiring one 4-bit multiplier digit per cycle.
module rsf_digit_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rsf_pkg::MUL_A_W-1:0] a,
	input  logic [rsf_pkg::MUL_B_W-1:0] b,
	output logic                         done,
	output logic [rsf_pkg::MUL_P_W-1:0] prod
);
	import rsf_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [MUL_CNT_W-1:0]  cnt_q;
	logic [MUL_A_W-1:0]    a_q;
	logic [MUL_P_W-1:0]    p_q;
	logic [MUL_A_W+DIG_W-1:0] pp;
	logic [MUL_A_W+DIG_W-1:0] hsum;

	// Upper field accumulates, lower field holds the multiplier digits left
	assign pp   = {{DIG_W{1'b0}}, a_q} * {{MUL_A_W{1'b0}}, p_q[DIG_W-1:0]};
	assign hsum = {{DIG_W{1'b0}}, p_q[MUL_P_W-1:MUL_B_W]} + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {hsum, p_q[MUL_B_W-1:DIG_W]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

FILE: rtl/core/rsf_regs.sv
// APB configuration register file for the rotor speed filter.
module rsf_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsf_pkg::ADDR_W-1:0] paddr,
	input  logic [rsf_pkg::DATA_W-1:0] pwdata,
	output logic [rsf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output rsf_pkg::cfg_t               cfg
);
	import rsf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_up        <= '0;
			cfg_q.alpha_down      <= '0;
			cfg_q.step_up_limit   <= RST_STEP_LIMIT;
			cfg_q.step_down_limit <= RST_STEP_LIMIT;
			cfg_q.max_speed       <= RST_MAX_SPEED;
			cfg_q.thrust_coeff    <= '0;
			cfg_q.moment_coeff    <= '0;
			cfg_q.spin_ccw        <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_ALPHA_UP:     cfg_q.alpha_up        <= pwdata[15:0];
				REG_ALPHA_DOWN:   cfg_q.alpha_down      <= pwdata[15:0];
				REG_STEP_UP:      cfg_q.step_up_limit   <= pwdata[15:0];
				REG_STEP_DOWN:    cfg_q.step_down_limit <= pwdata[15:0];
				REG_MAX_SPEED:    cfg_q.max_speed       <= pwdata[15:0];
				REG_THRUST_COEFF: cfg_q.thrust_coeff    <= pwdata[23:0];
				REG_MOMENT_COEFF: cfg_q.moment_coeff    <= pwdata[15:0];
				REG_SPIN_CCW:     cfg_q.spin_ccw        <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ALPHA_UP:     prdata = {16'b0, cfg_q.alpha_up};
			REG_ALPHA_DOWN:   prdata = {16'b0, cfg_q.alpha_down};
			REG_STEP_UP:      prdata = {16'b0, cfg_q.step_up_limit};
			REG_STEP_DOWN:    prdata = {16'b0, cfg_q.step_down_limit};
			REG_MAX_SPEED:    prdata = {16'b0, cfg_q.max_speed};
			REG_THRUST_COEFF: prdata = {8'b0, cfg_q.thrust_coeff};
			REG_MOMENT_COEFF: prdata = {16'b0, cfg_q.moment_coeff};
			REG_SPIN_CCW:     prdata = {31'b0, cfg_q.spin_ccw};
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/rotor_speed_filter_thrust_model.sv
// Top level: rotor speed filter with thrust and yaw torque model.
// The block takes no new command until the current result is in the output register; the four
// products (speed squared, thrust, torque, filter step) run one after another through a single
// digit-serial multiplier.
// Reset (arst_n low, asynchronous): held reference and filtered speed clear to zero,
// registers take their reset values, no result is pending.
module rotor_speed_filter_thrust_model (
	input  logic                        clk,
	input  logic                        arst_n,
	rsf_cmd_if.sink                     cmd,
	rsf_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsf_pkg::ADDR_W-1:0] paddr,
	input  logic [rsf_pkg::DATA_W-1:0] pwdata,
	output logic [rsf_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import rsf_pkg::*;

	// One step per product, then a slot to hand the result to the output register
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQ   = 6'b000010,
		ST_THR  = 6'b000100,
		ST_MOM  = 6'b001000,
		ST_FLT  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	// Filter state
	logic signed [15:0] held_q;
	logic signed [15:0] speed_q;

	// Per-transaction working registers
	logic signed [15:0] ref_q;
	logic [15:0]        alpha_q;
	logic [16:0]        dmag_q;
	logic               dneg_q;
	logic [31:0]        thrust_q;
	logic [31:0]        torque_q;
	logic signed [15:0] next_q;

	// Output register
	logic               res_valid_q;
	logic signed [15:0] res_now_q;
	logic [31:0]        res_thrust_q;
	logic [31:0]        res_torque_q;
	logic signed [15:0] res_next_q;

	// Shared multiplier
	logic                 mul_start;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic                 mul_done;
	logic [MUL_P_W-1:0]   mul_prod;

	logic                 cmd_acc;
	logic                 out_free;
	logic [15:0]          speed_mag;

	// Reference window
	logic signed [17:0]   held_x;
	logic signed [17:0]   win_hi;
	logic signed [17:0]   win_lo;
	logic signed [15:0]   ref_w;
	logic signed [16:0]   diff_w;
	logic [16:0]          dmag_w;

	// Product post-processing
	logic [31:0]          thrust_w;
	logic [31:0]          mom_w;
	logic [31:0]          torque_w;
	logic [33:0]          fprod_w;
	logic [34:0]          frnd_w;
	logic [18:0]          fstep_w;
	logic [19:0]          fsum_w;
	logic signed [15:0]   next_w;

	rsf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rsf_digit_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !res_valid_q || res.ready;

	// Magnitude of the speed; the most negative code maps to 32768 unsigned
	assign speed_mag = speed_q[15] ? (~speed_q + 16'd1) : speed_q;

	// Clamp the held reference into [s - step_down, s + step_up] at full width
	assign held_x = {{2{held_q[15]}}, held_q};
	assign win_hi = {{2{speed_q[15]}}, speed_q} + {2'b00, cfg.step_up_limit};
	assign win_lo = {{2{speed_q[15]}}, speed_q} - {2'b00, cfg.step_down_limit};

	always_comb begin
		priority if (held_x > win_hi) begin
			ref_w = win_hi[15:0];
		end else if (held_x < win_lo) begin
			ref_w = win_lo[15:0];
		end else begin
			ref_w = held_q;
		end
	end

	assign diff_w = {speed_q[15], speed_q} - {ref_w[15], ref_w};
	assign dmag_w = diff_w[16] ? (~diff_w + 17'd1) : diff_w;

	// Thrust saturates once the scaled square leaves 32 bits
	assign thrust_w = (mul_prod[55:48] != 8'd0) ? 32'hFFFF_FFFF : mul_prod[47:16];

	// Torque = -direction * m: clockwise gives +m, counter-clockwise gives -m
	assign mom_w = mul_prod[47:16];
	always_comb begin
		if (cfg.spin_ccw) begin
			if (mom_w[31] && (mom_w[30:0] != 31'd0)) begin
				torque_w = 32'h8000_0000;
			end else begin
				torque_w = ~mom_w + 32'd1;
			end
		end else begin
			torque_w = mom_w[31] ? 32'h7FFF_FFFF : mom_w;
		end
	end

	// Filter step: r + floor((a*(s-r) + 2^15) / 2^16), saturated to 16 bits
	assign fprod_w = dneg_q ? (~{1'b0, mul_prod[32:0]} + 34'd1) : {1'b0, mul_prod[32:0]};
	assign frnd_w  = {fprod_w[33], fprod_w} + 35'd32768;
	assign fstep_w = frnd_w[34:16];
	assign fsum_w  = {{4{ref_q[15]}}, ref_q} + {fstep_w[18], fstep_w};

	always_comb begin
		priority if (fsum_w[19:15] == 5'b00000 || fsum_w[19:15] == 5'b11111) begin
			next_w = fsum_w[15:0];
		end else if (fsum_w[19]) begin
			next_w = 16'sh8000;
		end else begin
			next_w = 16'sh7FFF;
		end
	end

	// Operand select; a command starts the square, later starts follow the product before
	always_comb begin
		mul_start = 1'b0;
		mul_a     = {16'b0, speed_mag};
		mul_b     = {8'b0, speed_mag};
		unique case (state_q)
			ST_IDLE: begin
				mul_start = cmd_acc;
			end
			ST_SQ: begin
				mul_start = mul_done;
				mul_a     = mul_prod[31:0];
				mul_b     = cfg.thrust_coeff;
			end
			ST_THR: begin
				mul_start = mul_done;
				mul_a     = thrust_w;
				mul_b     = {8'b0, cfg.moment_coeff};
			end
			ST_MOM: begin
				mul_start = mul_done;
				mul_a     = {15'b0, dmag_q};
				mul_b     = {8'b0, alpha_q};
			end
			ST_FLT, ST_OUT: begin
				mul_start = 1'b0;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			speed_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						// Latch a new command, clamped above at max_speed
						if (cmd.cmd_valid) begin
							held_q <= (cmd.cmd_speed > cfg.max_speed) ? cfg.max_speed
								: cmd.cmd_speed;
						end
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mul_done) state_q <= ST_THR;
				end
				ST_THR: begin
					if (mul_done) state_q <= ST_MOM;
				end
				ST_MOM: begin
					if (mul_done) state_q <= ST_FLT;
				end
				ST_FLT: begin
					if (mul_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					// Hold until the output register frees, then advance the filter
					if (out_free) begin
						speed_q <= next_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers, captured as each product completes
	always_ff @(posedge clk) begin
		if (state_q == ST_SQ && mul_done) begin
			ref_q   <= ref_w;
			alpha_q <= (ref_w > speed_q) ? cfg.alpha_up : cfg.alpha_down;
			dmag_q  <= dmag_w;
			dneg_q  <= diff_w[16];
		end
		if (state_q == ST_THR && mul_done) thrust_q <= thrust_w;
		if (state_q == ST_MOM && mul_done) torque_q <= torque_w;
		if (state_q == ST_FLT && mul_done) next_q   <= next_w;
	end

	// Output register: set on hand-off, drop once the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			res_now_q    <= speed_q;
			res_thrust_q <= thrust_q;
			res_torque_q <= torque_q;
			res_next_q   <= next_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.speed_now  = res_now_q;
	assign res.thrust_out = res_thrust_q;
	assign res.yaw_torque = res_torque_q;
	assign res.speed_next = res_next_q;

endmodule

FILE: test/rotor_speed_filter_thrust_model_test.sv
// Testbench for the rotor speed filter and thrust model: directed, random and backpressure runs.
`timescale 1ns / 1ps

module rotor_speed_filter_thrust_model_test;
	import rsf_pkg::*;

	localparam int     CYCLE_LIMIT  = 1000000;
	localparam int     DRAIN_CYCLES = 40;    // extra wait after the last expected result
	localparam int     PHASES       = 11;
	localparam int     PHASE_ITEMS  = 100;
	localparam int     LONG_HOLD    = 600;
	localparam longint THRUST_MAX   = 64'hFFFF_FFFF;
	localparam longint TORQUE_MAX   = 64'sd2147483647;
	localparam longint TORQUE_MIN   = -64'sd2147483648;

	// One result transaction as the block should produce it
	typedef struct {
		logic signed [15:0] speed_now;
		logic [31:0]        thrust_out;
		logic signed [31:0] yaw_torque;
		logic signed [15:0] speed_next;
	} rotor_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	rsf_cmd_if cmd_ch ();
	rsf_res_if res_ch ();

	// Predictor state: register copy, held reference and filtered speed
	cfg_t               model_cfg;
	logic signed [15:0] held_ref;
	logic signed [15:0] filt_speed;

	rotor_result_t expected_results[$];

	int  cycle_count   = 0;
	int  fail_count    = 0;
	int  sent_count    = 0;
	int  checked_count = 0;
	int  setting_count = 0;
	int  long_holds    = 0;
	bit  send_idle_on  = 1'b1;
	bit  recv_idle_on  = 1'b1;
	int  hold_request  = 0;
	int  hold_left     = 0;
	int  stall_left    = 0;

	rotor_speed_filter_thrust_model DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// Abort a run that hangs: the slowest correct run is far below this
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, expected_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Gap length for either side: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Advance the filter by one tick and return the result it reports.
	// All sums are formed in 64 bits so that clamps see the true value.
	function automatic rotor_result_t advance_rotor(logic take_cmd, logic signed [15:0] speed_cmd);
		rotor_result_t      o;
		longint             s, r, d, nxt, mag, torque, alpha;
		longint unsigned    sq, thr;
		logic signed [15:0] ceiling;

		ceiling = model_cfg.max_speed;
		s = longint'(filt_speed);
		// latch the new command, clamped above only
		if (take_cmd)
			held_ref = (speed_cmd > ceiling) ? ceiling : speed_cmd;

		// thrust from the speed before the update; the square drops the sign
		sq  = longint'(s * s);
		thr = (sq * longint'(model_cfg.thrust_coeff)) >> FRAC_W;
		if (thr > THRUST_MAX)
			thr = THRUST_MAX;

		// drag torque opposes the turning direction
		mag = longint'((thr * longint'(model_cfg.moment_coeff)) >> FRAC_W);
		if (model_cfg.spin_ccw) begin
			torque = -mag;
			if (torque < TORQUE_MIN)
				torque = TORQUE_MIN;
		end else begin
			torque = mag;
			if (torque > TORQUE_MAX)
				torque = TORQUE_MAX;
		end

		// clamp the reference to the step window around the speed
		r = longint'(held_ref);
		if (r > s + longint'(model_cfg.step_up_limit))
			r = s + longint'(model_cfg.step_up_limit);
		else if (r < s - longint'(model_cfg.step_down_limit))
			r = s - longint'(model_cfg.step_down_limit);

		// asymmetric decay, rounded to nearest with ties up
		alpha = (r > s) ? longint'(model_cfg.alpha_up) : longint'(model_cfg.alpha_down);
		d     = s - r;
		nxt   = r + ((alpha * d + 32768) >>> FRAC_W);
		if (nxt > 32767)
			nxt = 32767;
		if (nxt < -32768)
			nxt = -32768;
		filt_speed = nxt[15:0];

		o.speed_now  = s[15:0];
		o.thrust_out = thr[31:0];
		o.yaw_torque = torque[31:0];
		o.speed_next = nxt[15:0];
		return o;
	endfunction

	// Command speed with a bias toward the clamp and the current speed
	function automatic logic signed [15:0] random_speed();
		int t;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: t = int'($urandom_range(0, 65535)) - 32768;
			4, 5, 6:    t = int'(model_cfg.max_speed) + int'($urandom_range(0, 64)) - 32;
			7:          t = int'(filt_speed) + int'($urandom_range(0, 512)) - 256;
			8: begin
				case ($urandom_range(0, 3))
					0:       t = 32767;
					1:       t = -32768;
					2:       t = 0;
					default: t = -1;
				endcase
			end
			default:    t = int'($urandom_range(0, 4000)) - 2000;
		endcase
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		return t[15:0];
	endfunction

	// 16-bit register value with the extremes and a realistic decay band
	function automatic logic [15:0] pick_reg16();
		case ($urandom_range(0, 4))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 255));
			3:       return 16'($urandom_range(60000, 65535));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic report_mismatch(string field, longint want, longint got);
		$display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
			$time, field, checked_count, want, got);
		fail_count++;
	endtask

	// Compare one accepted result with the oldest expectation
	task automatic check_result();
		rotor_result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result transaction with no command outstanding", $time);
			fail_count++;
		end else begin
			want = expected_results.pop_front();
			if (res_ch.speed_now !== want.speed_now)
				report_mismatch("speed_now", want.speed_now, res_ch.speed_now);
			if (res_ch.thrust_out !== want.thrust_out)
				report_mismatch("thrust_out", want.thrust_out, res_ch.thrust_out);
			if (res_ch.yaw_torque !== want.yaw_torque)
				report_mismatch("yaw_torque", want.yaw_torque, res_ch.yaw_torque);
			if (res_ch.speed_next !== want.speed_next)
				report_mismatch("speed_next", want.speed_next, res_ch.speed_next);
		end
		checked_count++;
	endtask

	// Result side: check on every handshake, then pick the next ready.
	// A long hold-off requested by a test is counted down here.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			check_result();
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
			long_holds++;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			if (recv_idle_on && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Offer one command transaction; keep valid high on a zero gap so the next
	// item follows without a bubble. Predict at the accepting edge.
	task automatic send_command(logic take_cmd, logic signed [15:0] speed_cmd);
		int gap;
		gap = send_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.cmd_valid <= take_cmd;
		cmd_ch.cmd_speed <= speed_cmd;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		expected_results.push_back(advance_rotor(take_cmd, speed_cmd));
		sent_count++;
	endtask

	// Drop valid and wait until every expected result is in and the block is idle
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup phase, access phase, then idle with psel low
	task automatic write_register(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ALPHA_UP:     model_cfg.alpha_up        = value[15:0];
			REG_ALPHA_DOWN:   model_cfg.alpha_down      = value[15:0];
			REG_STEP_UP:      model_cfg.step_up_limit   = value[15:0];
			REG_STEP_DOWN:    model_cfg.step_down_limit = value[15:0];
			REG_MAX_SPEED:    model_cfg.max_speed       = value[15:0];
			REG_THRUST_COEFF: model_cfg.thrust_coeff    = value[23:0];
			REG_MOMENT_COEFF: model_cfg.moment_coeff    = value[15:0];
			REG_SPIN_CCW:     model_cfg.spin_ccw        = value[0];
		endcase
	endtask

	// Drain, then rewrite the whole register set
	task automatic load_settings(logic [15:0] a_up, logic [15:0] a_dn, logic [15:0] lim_up,
		logic [15:0] lim_dn, logic signed [15:0] top_speed, logic [23:0] thr_k,
		logic [15:0] mom_k, logic ccw);
		drain_results();
		write_register(REG_ALPHA_UP, 32'(a_up));
		write_register(REG_ALPHA_DOWN, 32'(a_dn));
		write_register(REG_STEP_UP, 32'(lim_up));
		write_register(REG_STEP_DOWN, 32'(lim_dn));
		write_register(REG_MAX_SPEED, 32'(top_speed));
		write_register(REG_THRUST_COEFF, 32'(thr_k));
		write_register(REG_MOMENT_COEFF, 32'(mom_k));
		write_register(REG_SPIN_CCW, 32'(ccw));
		setting_count++;
	endtask

	// Register reset values: zero alphas jump straight to the clamped
	// reference, and a command above the default ceiling is held there.
	task automatic test_reset_state();
		send_command(1'b1, 16'sd20000);
		send_command(1'b0, 16'sd0);
		send_command(1'b1, -16'sd5);
	endtask

	// Extremes: full-scale speeds both ways, thrust and torque saturation
	// in both spin directions, a negative ceiling, step windows and ties.
	task automatic test_corner_cases();
		load_settings(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 24'hFFFFFF,
			16'hFFFF, 1'b0);
		send_command(1'b1, 16'sh7FFF);
		send_command(1'b0, 16'sd0);
		send_command(1'b1, 16'sh8000);
		send_command(1'b0, 16'sd0);

		drain_results();
		write_register(REG_SPIN_CCW, 32'd1);
		send_command(1'b1, 16'sh7FFF);
		send_command(1'b0, 16'sd0);

		drain_results();
		write_register(REG_MAX_SPEED, 32'(-1000));
		send_command(1'b1, 16'sd5000);
		send_command(1'b1, 16'sh8000);
		send_command(1'b0, 16'sd0);

		// half-step alpha on the way up makes rounding ties
		load_settings(16'h8000, 16'hFFFF, 16'd100, 16'd50, 16'sh7FFF, 24'h010000,
			16'h8000, 1'b1);
		send_command(1'b1, 16'sd5000);
		repeat (3) send_command(1'b0, 16'sd0);
		send_command(1'b1, -16'sd5000);
		repeat (2) send_command(1'b0, 16'sd0);
	endtask

	// Random commands under a series of register settings; the first two
	// are all-maximum and all-minimum, and idling varies per setting
	task automatic test_random_settings();
		int p;
		int i;
		for (p = 0; p < PHASES; p++) begin
			if (p == 0)
				load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF,
					24'hFFFFFF, 16'hFFFF, 1'b1);
			else if (p == 1)
				load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'sh8000,
					24'h000000, 16'h0000, 1'b0);
			else
				load_settings(pick_reg16(), pick_reg16(), pick_reg16(), pick_reg16(),
					($urandom_range(0, 2) == 0) ? 16'sh7FFF : 16'($urandom_range(0, 65535)),
					($urandom_range(0, 2) == 0) ? 24'($urandom_range(0, 262143))
						: 24'($urandom_range(0, 16777215)),
					pick_reg16(), 1'($urandom_range(0, 1)));
			case (p % 4)
				0: begin send_idle_on = 1'b1; recv_idle_on = 1'b1; end
				1: begin send_idle_on = 1'b0; recv_idle_on = 1'b1; end
				2: begin send_idle_on = 1'b1; recv_idle_on = 1'b0; end
				default: begin send_idle_on = 1'b0; recv_idle_on = 1'b0; end
			endcase
			for (i = 0; i < PHASE_ITEMS; i++)
				send_command(1'($urandom_range(0, 9) < 7), random_speed());
		end
	endtask

	// Hold the result side off for a long stretch while commands keep coming,
	// so the block backs up and drops its input ready
	task automatic test_receiver_backpressure();
		int i;
		drain_results();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		hold_request = LONG_HOLD;
		for (i = 0; i < 25; i++)
			send_command(1'($urandom_range(0, 9) < 7), random_speed());
		recv_idle_on = 1'b1;
	endtask

	initial begin
		// known values on every input from time zero
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.cmd_valid = 1'b0;
		cmd_ch.cmd_speed = '0;
		res_ch.ready     = 1'b0;

		// predictor starts from the reset state
		model_cfg.alpha_up        = '0;
		model_cfg.alpha_down      = '0;
		model_cfg.step_up_limit   = RST_STEP_LIMIT;
		model_cfg.step_down_limit = RST_STEP_LIMIT;
		model_cfg.max_speed       = RST_MAX_SPEED;
		model_cfg.thrust_coeff    = '0;
		model_cfg.moment_coeff    = '0;
		model_cfg.spin_ccw        = 1'b0;
		held_ref                  = '0;
		filt_speed                = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_corner_cases();
		test_random_settings();
		test_receiver_backpressure();
		drain_results();

		if (expected_results.size() != 0) begin
			$display("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		$display("Checked %0d results from %0d command transactions over %0d register settings,",
			checked_count, sent_count, setting_count + 1);
		$display("with %0d long result-side hold-offs and %0d mismatches.",
			long_holds, fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
